[hdl/emrg_pkg.sv]
package emrg_pkg;

    // Field widths of the row beats
    localparam int JOIN_W  = 31;
    localparam int DROP_W  = 32;
    localparam int LABEL_W = 5;

    typedef struct packed {
        logic [JOIN_W-1:0] join_random;
        logic [DROP_W-1:0] drop_random;
        logic              last_row;
    } t_item_in;

    typedef struct packed {
        logic [JOIN_W-1:0] right_links;
        logic [DROP_W-1:0] down_links;
    } t_item_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic join_step;
        logic drop_step;
        logic clr_idx;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic join_end;
        logic drop_end;
        logic last;
    } t_status;

endpackage

[hdl/emrg_ctrl.sv]
module emrg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  emrg_pkg::t_status i_status,
    output emrg_pkg::t_cmd   o_cmd
);
    import emrg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_JOIN   = 4'b0010,
        S_DROP   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_out_valid || i_out_ready;

    // Sequence one row: load, join walk, drop walk (skipped on a last row), hand off
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_JOIN;
                end
            end
            S_JOIN: begin
                cmd.join_step = 1'b1;
                if (i_status.join_end) begin
                    cmd.clr_idx = 1'b1;
                    n_state     = i_status.last ? S_FINISH : S_DROP;
                end
            end
            S_DROP: begin
                cmd.drop_step = 1'b1;
                if (i_status.drop_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result beat until the receiver takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[hdl/emrg_dp.sv]
module emrg_dp #(
    parameter int COLUMNS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  emrg_pkg::t_cmd      i_cmd,
    input  emrg_pkg::t_item_in  i_item,
    output emrg_pkg::t_status   o_status,
    output emrg_pkg::t_item_out o_item
);
    import emrg_pkg::*;

    localparam int CW = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
    localparam logic [CW-1:0] LAST_JOIN = CW'(COLUMNS - 2);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    logic [LABEL_W-1:0] r_label [COLUMNS];
    logic [LABEL_W-1:0] r_next  [COLUMNS];
    logic [COLUMNS-1:0] r_carry;
    logic [JOIN_W-1:0]  r_join;
    logic [DROP_W-1:0]  r_drop;
    logic               r_last;
    logic [JOIN_W-1:0]  r_right;
    logic [DROP_W-1:0]  r_down;
    logic [CW-1:0]      r_idx;
    t_item_out          r_out;

    logic [CW-1:0]      idx_nxt;
    logic [LABEL_W-1:0] lab_a;
    logic [LABEL_W-1:0] lab_b;
    logic               do_join;
    logic [COLUMNS-1:0] member;
    logic [COLUMNS-1:0] prior_drop;
    logic               any_drop;
    logic               other_right;
    logic               down_bit;
    logic [LABEL_W-1:0] enc;

    assign idx_nxt = r_idx + CW'(1);
    assign lab_a   = r_label[r_idx];
    assign lab_b   = r_label[idx_nxt];
    assign do_join = (lab_a != lab_b) && (r_last || r_join[r_idx]);

    // Compare the current column's set against every lane
    always_comb begin
        other_right = 1'b0;
        for (int j = 0; j < COLUMNS; j++) begin
            member[j]     = (r_label[j] == lab_a);
            prior_drop[j] = member[j] && r_down[j];
            if (member[j] && (CW'(j) > r_idx)) begin
                other_right = 1'b1;
            end
        end
    end

    // Drop where asked, else force a drop at the set's rightmost column
    assign any_drop = |(member & r_drop[COLUMNS-1:0]);
    assign down_bit = r_drop[r_idx] || (!any_drop && !other_right);

    // Lowest column of this set already carried down, else this one
    always_comb begin
        enc = LABEL_W'(r_idx);
        for (int j = COLUMNS - 1; j >= 0; j--) begin
            if (prior_drop[j]) begin
                enc = LABEL_W'(j);
            end
        end
    end

    // Set labels and carried marks, one lane per column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            for (int j = 0; j < COLUMNS; j++) begin
                r_label[j] <= '0;
            end
        end else begin
            for (int j = 0; j < COLUMNS; j++) begin
                if (i_cmd.load) begin
                    if (!r_carry[j]) begin
                        r_label[j] <= LABEL_W'(j);
                    end
                end else if (i_cmd.join_step && do_join && (r_label[j] == lab_b)) begin
                    r_label[j] <= lab_a;
                end else if (i_cmd.finish) begin
                    r_label[j] <= r_last ? '0 : r_next[j];
                    r_carry[j] <= r_last ? 1'b0 : r_down[j];
                end
            end
        end
    end

    // Row walk: latch the beat, then one column per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load || i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.join_step || i_cmd.drop_step) begin
            r_idx <= idx_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_join  <= i_item.join_random;
            r_drop  <= i_item.drop_random;
            r_last  <= i_item.last_row;
            r_right <= '0;
            r_down  <= '0;
        end else begin
            if (i_cmd.join_step && do_join) begin
                r_right[r_idx] <= 1'b1;
            end
            if (i_cmd.drop_step) begin
                r_down[r_idx] <= down_bit;
                r_next[r_idx] <= down_bit ? enc : '0;
            end
        end
        if (i_cmd.finish) begin
            r_out.right_links <= r_right;
            r_out.down_links  <= r_down;
        end
    end

    assign o_status.join_end = (r_idx == LAST_JOIN);
    assign o_status.drop_end = (r_idx == LAST_COL);
    assign o_status.last     = r_last;
    assign o_item            = r_out;

endmodule

[hdl/eller_maze_row_generator_core.sv]
// Maze row generator (Eller's scheme), one row of COLUMNS cells per beat.
// Input channel i_in_valid / o_in_ready / i_in_data carries the join and
// drop random bits of a row and the last-row flag. Output channel
// o_out_valid / i_out_ready / o_out_data returns the right and down passage
// masks of that row, one result beat per input beat, in order.
// One row is worked on at a time. A beat is taken only while the block is
// idle; a join walk then visits one column pair per cycle and a drop walk
// one column per cycle, and a last row skips the drop walk. The walks run
// between the load and the hand-off, and the result is valid the cycle
// after the hand-off. No new beat is taken until the row before it has
// been handed off.
// A finished result sits in an output register, so the next row is taken
// while it waits; if the receiver still stalls when that row is done, the
// block holds it until the output register frees.
// Reset (synchronous, active low) clears all carried sets; the first row
// after reset, and the row after a last row, start every column fresh.
module eller_maze_row_generator_core #(
    parameter int COLUMNS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  emrg_pkg::t_item_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output emrg_pkg::t_item_out o_out_data
);
    import emrg_pkg::*;

    t_cmd    cmd;
    t_status status;

    emrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    emrg_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_data),
        .o_status (status),
        .o_item   (o_out_data)
    );

endmodule

[verif/emrg_row_checker.sv]
module emrg_row_checker #(
    parameter int COLUMNS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  emrg_pkg::t_item_in  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  emrg_pkg::t_item_out i_out_data,
    output int                  o_mismatches,
    output int                  o_rows_pending
);
    import emrg_pkg::*;

    // Shadow copy of the per-column set labels and the carried-down marks
    logic [LABEL_W-1:0] set_id [COLUMNS];
    logic [COLUMNS-1:0] carried_cols;
    t_item_out          expected_links [$];
    int                 mismatch_cnt = 0;

    // Work out the passage masks of one row and advance the set state
    function automatic t_item_out next_row_links(t_item_in beat);
        logic [LABEL_W-1:0] nxt_id [COLUMNS];
        logic [LABEL_W-1:0] old_id;
        logic [LABEL_W-1:0] new_id;
        logic [63:0]        row_m;
        logic [DROP_W-1:0]  drop_m;
        logic [DROP_W-1:0]  down_m;
        logic [DROP_W-1:0]  grp;
        logic [JOIN_W-1:0]  right_m;
        bit                 leader;
        bit                 found;
        int                 top;
        t_item_out          res;

        row_m   = (64'd1 << COLUMNS) - 64'd1;
        drop_m  = beat.drop_random & row_m[DROP_W-1:0];
        right_m = '0;
        down_m  = '0;

        // Start a fresh set in every column not carried from above
        for (int i = 0; i < COLUMNS; i++) begin
            if (!carried_cols[i]) begin
                set_id[i] = LABEL_W'(i);
            end
        end

        // Walk the pairs left to right, merging the right set into the left one
        for (int i = 0; i + 1 < COLUMNS; i++) begin
            if (set_id[i] != set_id[i+1] && (beat.last_row || beat.join_random[i])) begin
                old_id = set_id[i+1];
                new_id = set_id[i];
                for (int j = 0; j < COLUMNS; j++) begin
                    if (set_id[j] == old_id) begin
                        set_id[j] = new_id;
                    end
                end
                right_m[i] = 1'b1;
            end
        end

        // Last row: no drops, return to the post-reset state
        if (beat.last_row) begin
            for (int i = 0; i < COLUMNS; i++) begin
                set_id[i] = '0;
            end
            carried_cols    = '0;
            res.right_links = right_m;
            res.down_links  = '0;
            return res;
        end

        // Drop each set where its bits say, else at its rightmost column
        for (int i = 0; i < COLUMNS; i++) begin
            grp    = '0;
            leader = 1'b1;
            for (int j = 0; j < COLUMNS; j++) begin
                if (set_id[j] == set_id[i]) begin
                    grp[j] = 1'b1;
                    if (j < i) begin
                        leader = 1'b0;
                    end
                end
            end
            if (leader) begin
                if ((grp & drop_m) != '0) begin
                    down_m |= grp & drop_m;
                end else begin
                    top = i;
                    for (int j = i; j < COLUMNS; j++) begin
                        if (grp[j]) begin
                            top = j;
                        end
                    end
                    down_m[top] = 1'b1;
                end
            end
        end

        // Relabel carried columns to the lowest carried column of their set
        for (int i = 0; i < COLUMNS; i++) begin
            nxt_id[i] = '0;
            found     = 1'b0;
            if (down_m[i]) begin
                for (int j = 0; j <= i; j++) begin
                    if (!found && down_m[j] && set_id[j] == set_id[i]) begin
                        nxt_id[i] = LABEL_W'(j);
                        found     = 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < COLUMNS; i++) begin
            set_id[i] = nxt_id[i];
        end
        carried_cols = down_m[COLUMNS-1:0];

        res.right_links = right_m;
        res.down_links  = down_m;
        return res;
    endfunction

    // Check result beats against the oldest prediction, queue new ones
    always @(posedge i_clk) begin : track
        t_item_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < COLUMNS; i++) begin
                set_id[i] = '0;
            end
            carried_cols = '0;
            expected_links.delete();
            o_rows_pending <= 0;
            o_mismatches   <= mismatch_cnt;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_links.size() == 0) begin
                    $error("unexpected result beat: right_links %h down_links %h",
                           i_out_data.right_links, i_out_data.down_links);
                    mismatch_cnt++;
                end else begin
                    want = expected_links.pop_front();
                    if (i_out_data.right_links !== want.right_links) begin
                        $error("right_links mismatch: expected %h, actual %h",
                               want.right_links, i_out_data.right_links);
                        mismatch_cnt++;
                    end
                    if (i_out_data.down_links !== want.down_links) begin
                        $error("down_links mismatch: expected %h, actual %h",
                               want.down_links, i_out_data.down_links);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_links = {expected_links, next_row_links(i_in_data)};
            end
            o_rows_pending <= expected_links.size();
            o_mismatches   <= mismatch_cnt;
        end
    end

endmodule

[verif/eller_maze_row_generator_core_tb.sv]
module eller_maze_row_generator_core_tb;
    import emrg_pkg::*;

    localparam int COLUMNS      = 32;
    localparam int RANDOM_ROWS  = 932;
    localparam int CALM_ROWS    = 120;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_item_in  in_data;
    logic      out_valid;
    logic      out_ready;
    t_item_out out_data;
    bit        idle_bursts;
    int        mismatches;
    int        rows_pending;
    int        quiet_cycles;

    eller_maze_row_generator_core #(
        .COLUMNS (COLUMNS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    emrg_row_checker #(
        .COLUMNS (COLUMNS)
    ) u_row_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_mismatches   (mismatches),
        .o_rows_pending (rows_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_item_in make_row(logic [JOIN_W-1:0] join_bits,
                                          logic [DROP_W-1:0] drop_bits, logic last);
        t_item_in beat;
        beat.join_random = join_bits;
        beat.drop_random = drop_bits;
        beat.last_row    = last;
        return beat;
    endfunction

    // Mix sparse, dense, uniform and all-or-nothing masks
    function automatic logic [31:0] random_mask();
        case ($urandom_range(0, 5))
            0: return $urandom() & $urandom();
            1: return $urandom() & $urandom() & $urandom();
            2: return $urandom() | $urandom();
            3: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_item_in random_row();
        logic [31:0] join_bits;
        logic [31:0] drop_bits;
        join_bits = random_mask();
        drop_bits = random_mask();
        return make_row(join_bits[JOIN_W-1:0], drop_bits, $urandom_range(0, 7) == 0);
    endfunction

    // Present one beat, with an optional idle burst first; return once accepted
    task automatic send_row(input t_item_in beat);
        int gap;
        if (idle_bursts && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Hold off until every queued row has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (rows_pending != 0);
    endtask

    // Stall the result channel in random bursts
    initial begin : receiver
        int hold;
        hold      = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ready <= 1'b0;
            end else if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // End the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("eller_maze_row_generator_core_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        idle_bursts = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First row after reset: every column alone, forced drop everywhere
        send_row(make_row(31'h0, 32'h0, 1'b0));
        // Join everything, no drop bits: single forced drop at the right end
        send_row(make_row(31'h7FFF_FFFF, 32'h0, 1'b0));
        send_row(make_row(31'h0, 32'hFFFF_FFFF, 1'b0));
        send_row(make_row(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        // Whole row carried in one set: no right passage whatever the join bits
        send_row(make_row(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        // Last row on a single set, then a last row straight after it
        send_row(make_row(31'h0, 32'h0, 1'b1));
        send_row(make_row(31'h0, 32'hFFFF_FFFF, 1'b1));
        send_row(make_row(31'h5555_5555, 32'hAAAA_AAAA, 1'b0));
        send_row(make_row(31'h2AAA_AAAA, 32'h5555_5555, 1'b0));
        send_row(make_row(31'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_row(make_row(31'h0, 32'h0000_0001, 1'b0));
        send_row(make_row(31'h0000_FFFF, 32'hFFFF_0000, 1'b0));
        send_row(make_row(31'h7FFF_0000, 32'h0000_FFFF, 1'b0));
        send_row(make_row(31'h1234_5678, 32'h0F0F_0F0F, 1'b0));
        send_row(make_row(31'h4000_0000, 32'h8000_0001, 1'b0));
        send_row(make_row(31'h0000_0001, 32'h0, 1'b0));
        send_row(make_row(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_row(make_row(31'h3C3C_3C3C, 32'h0, 1'b0));

        wait_drained();

        // Random rows; the tail runs with no idling on either side
        for (int n = 0; n < RANDOM_ROWS; n++) begin
            if (n == RANDOM_ROWS - CALM_ROWS) begin
                idle_bursts = 1'b0;
            end
            send_row(random_row());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && rows_pending == 0) begin
            $display("eller_maze_row_generator_core_tb OK");
        end else begin
            $display("eller_maze_row_generator_core_tb NOT OK");
        end
        $finish;
    end

endmodule
